>>> sv/fts_pkg.sv
`default_nettype none
package fts_pkg;

	localparam int FREQ_W       = 30;
	localparam int TICK_W       = 48;
	localparam int HOST_W       = 48;
	localparam int DEV_W        = 48;
	localparam int RTT_W        = 32;
	localparam int TS_W         = 56;
	localparam int IN_DATA_W    = TICK_W + HOST_W + DEV_W + RTT_W;
	localparam int OUT_DATA_W   = ((TS_W + 7) / 8) * 8;
	localparam int WRAP_SECONDS = 256;
	localparam int SUM_W        = 64;
	localparam int MUL_CH       = 22;
	localparam int MUL_STEPS    = (SUM_W + MUL_CH - 1) / MUL_CH;
	localparam int MUL_CNT_W    = $clog2(MUL_STEPS);
	localparam int PROD_W       = 84;
	localparam int DIVR_W       = FREQ_W + $clog2(WRAP_SECONDS + 1);
	localparam int DIV_CNT_W    = $clog2(PROD_W);
	localparam int MS_W         = 58;
	localparam int SW           = 62;
	localparam int MS_SCALE     = 1000;
	localparam int US_SCALE     = 1000000;
	localparam int PREV_MS_MIN  = 50;
	localparam int FREQ_RESET   = 1000000;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HZ  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_HZ = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_PREV,
		OP_DEV,
		OP_WRAP,
		OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_GO,
		S_MUL_WAIT,
		S_DIV_WAIT,
		S_WRAP_GO,
		S_DECIDE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic ld_in;
		logic clear;
		logic mul_go;
		logic div_go;
		logic save_div;
		logic decide;
		logic emit;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic in_clear;
		logic mul_done;
		logic div_done;
		logic rebase;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> sv/frame_timestamp_rebaser.sv
// frame timestamp rebaser: turns a wrapping frame tick count into an absolute
// microsecond timestamp, rebasing from a sampled device clock when needed.
// input channel s_axis: one transaction per frame, tuser set means clear the
// tick, host and base state (no result for it). output channel m_axis: one result per frame.
// config port: cfg_we / cfg_index / cfg_data, write only while idle;
// index 0 is the frame tick rate, index 1 the device tick rate, in hertz.
// each frame runs through a shared three-step multiplier and an 84-step
// restoring divider; the divider sets the pace. a frame without rebase takes
// three multiply/divide passes; a rebase adds the device conversion and the
// wrap-period division. a clear transaction is handled without leaving idle.
// the result sits in an output register; the next frame is taken while it
// waits, and a frame only stalls at its end if that register is still full.
// reset returns both rates to 1 MHz and clears the tick, host and base state.
`default_nettype none
module frame_timestamp_rebaser (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [fts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [fts_pkg::FREQ_W-1:0]         cfg_data,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// frame_ticks, host_ms, device_time, device_rtt
	input  wire [fts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// command
	input  wire                               s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// timestamp_us
	output logic [fts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// rebased
	output logic                              m_axis_tuser
);
	import fts_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	fts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_axis_tvalid)
		else $error("result register not loaded");

	a_unit_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.mul_done && sts.div_done))
		else $error("multiplier and divider finished together");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_go || cmd.div_go || cmd.emit) |-> !s_axis_tready)
		else $error("input accepted mid-frame");

endmodule
`default_nettype wire

>>> sv/fts_mul.sv
`default_nettype none
module fts_mul (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          go,
	input  wire [fts_pkg::SUM_W-1:0]     a,
	input  wire [fts_pkg::FREQ_W-1:0]    m,
	output logic                         done,
	output logic [fts_pkg::PROD_W-1:0]   prod
);
	import fts_pkg::*;

	localparam int AW    = MUL_STEPS * MUL_CH;
	localparam int ACC_W = AW + FREQ_W;

	logic [AW-1:0]            a_q;
	logic [FREQ_W-1:0]        m_q;
	logic [ACC_W-1:0]         acc_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [MUL_CH+FREQ_W-1:0] pp;

	// top chunk first, accumulator shifts up one chunk per step
	assign pp = a_q[AW-1 -: MUL_CH] * m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= AW'(a);
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q << MUL_CH;
			acc_q <= (acc_q << MUL_CH) + ACC_W'(pp);
		end
	end

	assign done = done_q;
	assign prod = acc_q[PROD_W-1:0];

endmodule
`default_nettype wire

>>> sv/fts_div.sv
`default_nettype none
module fts_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          go,
	input  wire [fts_pkg::PROD_W-1:0]    dividend,
	input  wire [fts_pkg::DIVR_W-1:0]    divisor,
	output logic                         done,
	output logic [fts_pkg::PROD_W-1:0]   quo,
	output logic [fts_pkg::DIVR_W-1:0]   rem
);
	import fts_pkg::*;

	logic [PROD_W-1:0]    quo_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVR_W:0]      trial;
	logic [DIVR_W:0]      diff;
	logic                 ge;

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

>>> sv/fts_dp.sv
`default_nettype none
module fts_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [fts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [fts_pkg::FREQ_W-1:0]       cfg_data,
	input  wire [fts_pkg::IN_DATA_W-1:0]    in_data,
	input  wire                             in_user,
	input  fts_pkg::dp_cmd_t                cmd,
	output fts_pkg::dp_sts_t                sts,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [fts_pkg::OUT_DATA_W-1:0]  out_data,
	output logic                            out_user
);
	import fts_pkg::*;

	logic [FREQ_W-1:0] f_q, d_q, f, d;
	logic [TICK_W-1:0] ticks_q, last_ticks_q, diff;
	logic [HOST_W-1:0] host_q, last_host_q;
	logic [DEV_W-1:0]  dev_q;
	logic [RTT_W-1:0]  rtt_q;
	logic [SUM_W-1:0]  base_q, b_q, sum, base_new, np;
	logic [MS_W-1:0]   tick_mag_q, prev_ms_q;
	logic [TS_W-1:0]   ts_q, out_ts_q;
	logic              rebase_q, out_reb_q, out_valid_q;
	logic              neg, dec, abn, rebase_c;
	logic [SUM_W:0]    sum_w;
	logic [DIVR_W-1:0] period;
	logic [SUM_W-1:0]  mul_a;
	logic [FREQ_W-1:0] mul_m;
	logic [PROD_W-1:0] prod, div_n, quo;
	logic [DIVR_W-1:0] div_d, rem;
	logic              mul_done, div_done;
	logic signed [SW-1:0] host_diff, tick_ms, lhs, rhs;

	assign f = (f_q == '0) ? FREQ_W'(1) : f_q;
	assign d = (d_q == '0) ? FREQ_W'(1) : d_q;

	assign neg    = ticks_q < last_ticks_q;
	assign diff   = neg ? last_ticks_q - ticks_q : ticks_q - last_ticks_q;
	assign period = DIVR_W'(f) * DIVR_W'(WRAP_SECONDS);
	assign sum_w  = {1'b0, base_q} + (SUM_W + 1)'(ticks_q);
	assign sum    = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];

	// rebase decision
	assign dec       = neg && ({diff, 1'b0} > (TICK_W + 1)'(f));
	assign host_diff = $signed(SW'(host_q)) - $signed(SW'(last_host_q));
	assign tick_ms   = neg ? -$signed(SW'(tick_mag_q)) : $signed(SW'(tick_mag_q));
	assign lhs       = host_diff - tick_ms;
	assign rhs       = $signed(SW'(prev_ms_q >> 1));
	assign abn       = lhs >= rhs;
	assign rebase_c  = (base_q == '0)
	                || ((dec || abn) && (ticks_q != '0 || last_ticks_q != '0))
	                || (prev_ms_q <= MS_W'(PREV_MS_MIN));

	// new base from wrap-period quotient and remainder
	assign np       = b_q - SUM_W'(rem);
	assign base_new = (SUM_W'(rem) < SUM_W'(ticks_q))
	                ? ((quo == '0) ? '0 : np - SUM_W'(period)) : np;

	always_comb begin
		mul_a = sum;
		mul_m = FREQ_W'(US_SCALE);
		div_n = prod;
		div_d = DIVR_W'(f);
		case (cmd.op)
			OP_TICK: begin
				mul_a = SUM_W'(diff);
				mul_m = FREQ_W'(MS_SCALE);
			end
			OP_PREV: begin
				mul_a = SUM_W'(last_ticks_q);
				mul_m = FREQ_W'(MS_SCALE);
			end
			OP_DEV: begin
				mul_a = SUM_W'(dev_q) + SUM_W'(rtt_q >> 1);
				mul_m = f;
				div_d = DIVR_W'(d);
			end
			OP_WRAP: begin
				div_n = PROD_W'(b_q);
				div_d = period;
			end
			default: ;
		endcase
	end

	fts_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.m      (mul_m),
		.done   (mul_done),
		.prod   (prod)
	);

	fts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q          <= FREQ_W'(FREQ_RESET);
			d_q          <= FREQ_W'(FREQ_RESET);
			last_ticks_q <= '0;
			last_host_q  <= '0;
			base_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_HZ:  f_q <= cfg_data;
					REG_DEVICE_HZ: d_q <= cfg_data;
				endcase
			end
			if (cmd.clear) begin
				last_ticks_q <= '0;
				last_host_q  <= '0;
				base_q       <= '0;
			end else if (cmd.save_div && cmd.op == OP_WRAP) begin
				base_q <= base_new;
			end
			if (cmd.emit) begin
				last_ticks_q <= ticks_q;
				last_host_q  <= host_q;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			ticks_q <= in_data[TICK_W-1:0];
			host_q  <= in_data[TICK_W +: HOST_W];
			dev_q   <= in_data[TICK_W+HOST_W +: DEV_W];
			rtt_q   <= in_data[TICK_W+HOST_W+DEV_W +: RTT_W];
		end
		if (cmd.save_div) begin
			case (cmd.op)
				OP_TICK: tick_mag_q <= quo[MS_W-1:0];
				OP_PREV: prev_ms_q  <= quo[MS_W-1:0];
				OP_DEV:  b_q <= (|quo[PROD_W-1:SUM_W]) ? '1 : quo[SUM_W-1:0];
				OP_OUT:  ts_q <= (|quo[PROD_W-1:TS_W]) ? '1 : quo[TS_W-1:0];
				default: ;
			endcase
		end
		if (cmd.decide)
			rebase_q <= rebase_c;
		if (cmd.emit) begin
			out_ts_q  <= ts_q;
			out_reb_q <= rebase_q;
		end
	end

	assign sts.in_clear = in_user;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.rebase   = rebase_c;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = OUT_DATA_W'(out_ts_q);
	assign out_user  = out_reb_q;

endmodule
`default_nettype wire

>>> sv/fts_ctrl.sv
`default_nettype none
module fts_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  fts_pkg::dp_sts_t  sts,
	output fts_pkg::dp_cmd_t  cmd
);
	import fts_pkg::*;

	state_t state_q, state_d;
	op_t    op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_TICK;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		cmd      = '0;
		cmd.op   = op_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					if (sts.in_clear) begin
						cmd.clear = 1'b1;
					end else begin
						op_d    = OP_TICK;
						state_d = S_MUL_GO;
					end
				end
			end
			S_MUL_GO: begin
				cmd.mul_go = 1'b1;
				state_d    = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (sts.mul_done) begin
					cmd.div_go = 1'b1;
					state_d    = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.save_div = 1'b1;
					unique case (op_q)
						OP_TICK: begin
							op_d    = OP_PREV;
							state_d = S_MUL_GO;
						end
						OP_PREV: state_d = S_DECIDE;
						OP_DEV: begin
							op_d    = OP_WRAP;
							state_d = S_WRAP_GO;
						end
						OP_WRAP: begin
							op_d    = OP_OUT;
							state_d = S_MUL_GO;
						end
						OP_OUT: state_d = S_EMIT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WRAP_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DIV_WAIT;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				op_d       = sts.rebase ? OP_DEV : OP_OUT;
				state_d    = S_MUL_GO;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire
